[rtl/mdcw_pkg.sv]
// ----------------------------------------------------------------------------
// mdcw_pkg
// Types and constants shared by the packet deframer and channel watch files.
// ----------------------------------------------------------------------------
package mdcw_pkg;

  localparam logic [7:0] START_V1    = 8'hFE;
  localparam logic [7:0] START_V2    = 8'hFD;
  localparam logic [7:0] RC_MSG      = 8'd65;
  localparam logic [8:0] CHAN_BASE   = 9'd18;
  localparam logic [8:0] OVERHEAD_V1 = 9'd8;
  localparam logic [8:0] OVERHEAD_V2 = 9'd12;
  localparam logic [4:0] CHAN_OFFSET = 5'd5;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic {
    REG_CHANNEL_COUNT = 1'b0,
    REG_UNMAPPED      = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic fwd_valid;
    logic fwd_last;
    logic skipped;
  } frame_info_t;

  typedef struct packed {
    logic        check;
    logic [6:0]  word_idx;
    logic [15:0] word;
  } chan_req_t;

  typedef struct packed {
    logic        changed;
    logic [4:0]  number;
    logic [15:0] value;
  } chan_evt_t;

endpackage

[rtl/mdcw_byte_if.sv]
// ----------------------------------------------------------------------------
// mdcw_byte_if
// Valid/ready channel carrying one received serial byte per beat.
// ----------------------------------------------------------------------------
interface mdcw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

[rtl/mdcw_result_if.sv]
// ----------------------------------------------------------------------------
// mdcw_result_if
// Valid/ready channel carrying one deframer result per beat.
// ----------------------------------------------------------------------------
interface mdcw_result_if;
  logic        valid;
  logic        ready;
  logic        fwd_valid;
  logic [7:0]  fwd_byte;
  logic        fwd_last;
  logic        skipped;
  logic        chan_changed;
  logic [4:0]  chan_number;
  logic [15:0] chan_value;

  modport source (
    output valid, output fwd_valid, output fwd_byte, output fwd_last,
    output skipped, output chan_changed, output chan_number, output chan_value,
    input ready
  );
  modport sink (
    input valid, input fwd_valid, input fwd_byte, input fwd_last,
    input skipped, input chan_changed, input chan_number, input chan_value,
    output ready
  );
endinterface

[rtl/mavlink_deframer_channel_watch.sv]
// ----------------------------------------------------------------------------
// mavlink_deframer_channel_watch
// MAVLink v1/v2 packet deframer with an RC channel change watch.
//
//   channel  | role   | beat contents
//   ---------+--------+---------------------------------------------------
//   rx       | sink   | one received serial byte
//   res      | source | forward flags and byte, skip flag, channel change
//   APB      | slave  | register 0: channel_count (saturates at maximum)
//
// One byte is taken every clock cycle unless the result channel stalls;
// each byte yields exactly one result. A byte goes into the input register,
// and a single pass of logic then updates the frame state and channel store
// and loads the result register once the result register can advance.
// While a result waits, the input register still takes one more byte.
// Reset clears the frame state, the channel store and the channel count.
// ----------------------------------------------------------------------------
module mavlink_deframer_channel_watch #(
  parameter int unsigned MAX_CHANNELS = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  mdcw_byte_if.sink                       rx,
  mdcw_result_if.source                   res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mdcw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [mdcw_pkg::APB_DATA_W-1:0] pwdata,
  output logic [mdcw_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int unsigned CNT_W = $clog2(MAX_CHANNELS + 1);

  logic                  s1_valid;
  logic [7:0]            s1_byte;
  logic                  advance;
  logic                  step;
  logic [CNT_W-1:0]      channel_count;
  mdcw_pkg::frame_info_t info;
  mdcw_pkg::chan_req_t   req;
  mdcw_pkg::chan_evt_t   evt;

  assign advance  = !res.valid || res.ready;
  assign step     = s1_valid && advance;
  assign rx.ready = !s1_valid || advance;

  mdcw_apb_regs #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .CNT_W        (CNT_W)
  ) u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .channel_count (channel_count)
  );

  mdcw_frame_track u_frame (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (s1_byte),
    .info    (info),
    .req     (req)
  );

  mdcw_chan_watch #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .CNT_W        (CNT_W)
  ) u_watch (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .channel_count (channel_count),
    .req           (req),
    .evt           (evt)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res.fwd_valid    <= info.fwd_valid;
      res.fwd_byte     <= info.fwd_valid ? s1_byte : 8'd0;
      res.fwd_last     <= info.fwd_last;
      res.skipped      <= info.skipped;
      res.chan_changed <= evt.changed;
      res.chan_number  <= evt.number;
      res.chan_value   <= evt.value;
    end
  end

endmodule

[rtl/mdcw_apb_regs.sv]
// ----------------------------------------------------------------------------
// mdcw_apb_regs
// APB register file holding the watched channel count, saturated on write.
// ----------------------------------------------------------------------------
module mdcw_apb_regs #(
  parameter int unsigned MAX_CHANNELS = 14,
  parameter int unsigned CNT_W        = $clog2(MAX_CHANNELS + 1)
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mdcw_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [mdcw_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mdcw_pkg::APB_DATA_W-1:0]    prdata,
  output logic                               pready,
  output logic [CNT_W-1:0]                   channel_count
);

  localparam logic [mdcw_pkg::APB_DATA_W-1:0] MAX_WORD =
    mdcw_pkg::APB_DATA_W'(MAX_CHANNELS);

  mdcw_pkg::reg_sel_t sel;
  logic               wr_en;
  logic [CNT_W-1:0]   channel_count_next;

  assign sel    = mdcw_pkg::reg_sel_t'(paddr[2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (sel == mdcw_pkg::REG_CHANNEL_COUNT);

  always_comb begin
    if (pwdata > MAX_WORD) begin
      channel_count_next = CNT_W'(MAX_CHANNELS);
    end else begin
      channel_count_next = pwdata[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= '0;
    end else if (wr_en) begin
      channel_count <= channel_count_next;
    end
  end

  always_comb begin
    unique case (sel)
      mdcw_pkg::REG_CHANNEL_COUNT: prdata = mdcw_pkg::APB_DATA_W'(channel_count);
      default:                     prdata = '0;
    endcase
  end

endmodule

[rtl/mdcw_frame_track.sv]
// ----------------------------------------------------------------------------
// mdcw_frame_track
// Start byte hunt, packet position tracking and channel word assembly.
// ----------------------------------------------------------------------------
module mdcw_frame_track (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  logic [7:0]             rx_byte,
  output mdcw_pkg::frame_info_t  info,
  output mdcw_pkg::chan_req_t    req
);

  logic       in_packet;
  logic       is_v2;
  logic [8:0] byte_index;
  logic [7:0] payload_length;
  logic [7:0] message_id;
  logic [7:0] low_byte_hold;

  logic       is_start;
  logic [8:0] total;
  logic [9:0] idx_plus1;
  logic       last;
  logic       id_slot;
  logic [8:0] rel_idx;

  assign is_start  = (rx_byte == mdcw_pkg::START_V1) || (rx_byte == mdcw_pkg::START_V2);
  assign total     = (is_v2 ? mdcw_pkg::OVERHEAD_V2 : mdcw_pkg::OVERHEAD_V1) +
                     9'(payload_length);
  assign idx_plus1 = 10'(byte_index) + 10'd1;
  assign last      = in_packet && (byte_index != 9'd0) && (idx_plus1 >= 10'(total));
  assign id_slot   = is_v2 ? (byte_index == 9'd7) : (byte_index == 9'd5);
  assign rel_idx   = byte_index - mdcw_pkg::CHAN_BASE;

  always_comb begin
    info.fwd_valid = in_packet || is_start;
    info.fwd_last  = last;
    info.skipped   = !in_packet && !is_start;
    req.check      = in_packet && (byte_index > mdcw_pkg::CHAN_BASE) && byte_index[0] &&
                     (message_id == mdcw_pkg::RC_MSG);
    req.word_idx   = rel_idx[7:1];
    req.word       = {rx_byte, low_byte_hold};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_packet      <= 1'b0;
      is_v2          <= 1'b0;
      byte_index     <= '0;
      payload_length <= '0;
      message_id     <= '0;
      low_byte_hold  <= '0;
    end else if (step) begin
      if (!in_packet) begin
        if (is_start) begin
          in_packet      <= 1'b1;
          is_v2          <= (rx_byte == mdcw_pkg::START_V2);
          byte_index     <= 9'd1;
          payload_length <= '0;
          message_id     <= '0;
          low_byte_hold  <= '0;
        end
      end else begin
        if (byte_index == 9'd1) begin
          payload_length <= rx_byte;
        end
        if (id_slot) begin
          message_id <= rx_byte;
        end
        if ((byte_index >= mdcw_pkg::CHAN_BASE) && !byte_index[0]) begin
          low_byte_hold <= rx_byte;
        end
        if (last) begin
          in_packet  <= 1'b0;
          byte_index <= '0;
        end else begin
          byte_index <= idx_plus1[8:0];
        end
      end
    end
  end

endmodule

[rtl/mdcw_chan_watch.sv]
// ----------------------------------------------------------------------------
// mdcw_chan_watch
// Stored RC channel words; compares each assembled word and reports changes.
// ----------------------------------------------------------------------------
module mdcw_chan_watch #(
  parameter int unsigned MAX_CHANNELS = 14,
  parameter int unsigned CNT_W        = $clog2(MAX_CHANNELS + 1),
  parameter int unsigned IDX_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [CNT_W-1:0]      channel_count,
  input  mdcw_pkg::chan_req_t   req,
  output mdcw_pkg::chan_evt_t   evt
);

  logic [15:0]      channel_values [MAX_CHANNELS];
  logic             hit;
  logic [IDX_W-1:0] ch;
  logic [15:0]      stored;
  logic             differs;

  assign hit = req.check &&
               (8'(req.word_idx) < 8'(channel_count)) &&
               (8'(req.word_idx) < 8'(MAX_CHANNELS));
  assign ch  = req.word_idx[IDX_W-1:0];

  always_comb begin
    stored = '0;
    if (hit) begin
      stored = channel_values[ch];
    end
  end

  assign differs = hit && (stored != req.word);

  always_comb begin
    evt.changed = differs;
    evt.number  = differs ? (5'(ch) + mdcw_pkg::CHAN_OFFSET) : 5'd0;
    evt.value   = differs ? req.word : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        channel_values[i] <= '0;
      end
    end else if (step && differs) begin
      channel_values[ch] <= req.word;
    end
  end

endmodule
